// ===== sv/pcl_pkg.sv =====
// Shared types, widths and constants of the PSK Costas carrier loop.
// Holds the quarter-wave sine table and its lookup function.
// No dependencies.
package pcl_pkg;

    // Sample, phase and table sizes
    localparam int SAMPLE_WIDTH    = 16;
    localparam int PHASE_WIDTH     = 32;
    localparam int SINE_TABLE_BITS = 10;

    localparam int FRAC_BITS = SAMPLE_WIDTH - 2;
    localparam int GAIN_W    = 31;
    localparam int CFG_IDX_W = 2;

    // Sine/cosine: signed Q1.14
    localparam int SINE_W     = 16;
    localparam int SINE_MAG_W = 15;
    localparam int SINE_ONE   = 16384;
    localparam int SINE_QB    = SINE_TABLE_BITS - 2;
    localparam int SINE_QTR   = 2 ** SINE_QB;

    // 8-PSK factor sqrt2-1 in Q16
    localparam int K8PSK = 27146;

    // Datapath widths
    localparam int MIX_W   = SAMPLE_WIDTH + SINE_W;
    localparam int SUM_W   = MIX_W + 1;
    localparam int PA_W    = SAMPLE_WIDTH + 1;
    localparam int KOP_W   = (PA_W > 17) ? PA_W : 17;
    localparam int EPROD_W = 2 * KOP_W;
    localparam int EW      = EPROD_W + 2;
    localparam int ERR_W   = SAMPLE_WIDTH;
    localparam int GPROD_W = GAIN_W + 1 + ERR_W;
    localparam int GTERM_W = GPROD_W - FRAC_BITS;
    localparam int FSUM_W  = GTERM_W + 1;

    // One radian per sample in phase units, rounded down
    localparam logic [PHASE_WIDTH-1:0] FREQ_LIMIT =
        PHASE_WIDTH'(((64'd1 << PHASE_WIDTH) * 64'd1000000000) / 64'd6283185307);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd2;

    // Error detector codes
    localparam logic [1:0] MODE_BPSK = 2'd0;
    localparam logic [1:0] MODE_QPSK = 2'd1;
    localparam logic [1:0] MODE_8PSK = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX,
        S_ROUND,
        S_ERR_MUL,
        S_ERR_FORM,
        S_GAIN,
        S_UPDATE
    } t_state;

    // Datapath commands, one step per flag
    typedef struct packed {
        logic load_in;
        logic mix;
        logic round;
        logic err_mul;
        logic err_form;
        logic gain;
        logic update;
    } t_dp_cmd;

    typedef logic [SINE_MAG_W-1:0] t_sine_lut [SINE_QTR];

    // First quadrant: s(x) = a*x - b*x^3 + c*x^5 in Q16, then to Q14
    function automatic t_sine_lut build_sine_lut();
        t_sine_lut lut;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        for (int m = 0; m < SINE_QTR; m++) begin
            x  = 64'(m) << (16 - SINE_QB);
            x2 = (x * x) >> 16;
            t  = 64'd42048 - ((x2 * 64'd4640) >> 16);
            t  = 64'd102944 - ((x2 * t) >> 16);
            s  = (x * t) >> 16;
            s  = (s + 64'd2) >> 2;
            if (s > 64'(SINE_ONE)) begin
                s = 64'(SINE_ONE);
            end
            lut[m] = SINE_MAG_W'(s);
        end
        return lut;
    endfunction

    localparam t_sine_lut SINE_LUT = build_sine_lut();

    // Full-circle sine by quarter-wave symmetry
    function automatic logic signed [SINE_W-1:0] sine_q14(
        input logic [SINE_TABLE_BITS-1:0] idx
    );
        logic [1:0]                quad;
        logic [SINE_QB-1:0]        k;
        logic [SINE_QB:0]          m;
        logic [SINE_MAG_W-1:0]     mag;
        logic signed [SINE_W-1:0]  sv;
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        k    = idx[SINE_QB-1:0];
        m    = quad[0] ? ((SINE_QB+1)'(SINE_QTR) - {1'b0, k}) : {1'b0, k};
        mag  = m[SINE_QB] ? SINE_MAG_W'(SINE_ONE) : SINE_LUT[m[SINE_QB-1:0]];
        sv   = signed'(SINE_W'(mag));
        return quad[1] ? -sv : sv;
    endfunction

endpackage

// ===== sv/pcl_ctrl.sv =====
// Sequencer of the PSK Costas carrier loop: steps one sample through
// the datapath and owns the input stall and output valid. Uses pcl_pkg.
module pcl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output pcl_pkg::t_dp_cmd o_cmd
);
    import pcl_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MIX;
                end
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = S_ROUND;
            end
            S_ROUND: begin
                // hold until the output register is free or drains this edge
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.round = 1'b1;
                    n_state     = S_ERR_MUL;
                end
            end
            S_ERR_MUL: begin
                o_cmd.err_mul = 1'b1;
                n_state       = S_ERR_FORM;
            end
            S_ERR_FORM: begin
                o_cmd.err_form = 1'b1;
                n_state        = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.round | (r_out_valid & i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/pcl_dpath.sv =====
// Datapath of the PSK Costas carrier loop: mixer, phase detector, loop
// filter, NCO and configuration registers. Uses pcl_pkg.
module pcl_dpath (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  pcl_pkg::t_dp_cmd                          i_cmd,
    input  logic                                      i_cfg_valid,
    input  logic [pcl_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [pcl_pkg::GAIN_W-1:0]                i_cfg_data,
    input  logic signed [pcl_pkg::SAMPLE_WIDTH-1:0]   i_in_i,
    input  logic signed [pcl_pkg::SAMPLE_WIDTH-1:0]   i_in_q,
    output logic signed [pcl_pkg::SAMPLE_WIDTH-1:0]   o_out_i,
    output logic signed [pcl_pkg::SAMPLE_WIDTH-1:0]   o_out_q
);
    import pcl_pkg::*;

    localparam logic signed [SUM_W-1:0]  RND14   = SUM_W'(2 ** 13);
    localparam logic signed [SUM_W-1:0]  SMAX    = SUM_W'(2 ** (SAMPLE_WIDTH - 1) - 1);
    localparam logic signed [SUM_W-1:0]  SMIN    = -SUM_W'(2 ** (SAMPLE_WIDTH - 1));
    localparam logic signed [EW-1:0]     RND_F   = EW'(2 ** (FRAC_BITS - 1));
    localparam logic signed [EW-1:0]     RND16   = EW'(2 ** 15);
    localparam logic signed [EW-1:0]     ERR_ONE = EW'(2 ** FRAC_BITS);
    localparam logic signed [GPROD_W-1:0] GRND   = GPROD_W'(2 ** (FRAC_BITS - 1));
    localparam logic signed [FSUM_W-1:0] FREQ_HI = FSUM_W'({1'b0, FREQ_LIMIT});
    localparam logic signed [FSUM_W-1:0] FREQ_LO = -FREQ_HI;

    // Configuration and loop state
    logic [1:0]                      r_mode;
    logic [GAIN_W-1:0]               r_alpha;
    logic [GAIN_W-1:0]               r_beta;
    logic [PHASE_WIDTH-1:0]          r_phase;
    logic signed [PHASE_WIDTH-1:0]   r_nco_freq;

    // Payload
    logic signed [SAMPLE_WIDTH-1:0]  r_xi;
    logic signed [SAMPLE_WIDTH-1:0]  r_xq;
    logic signed [SINE_W-1:0]        r_sin;
    logic signed [SINE_W-1:0]        r_cos;
    logic signed [MIX_W-1:0]         r_p_ic;
    logic signed [MIX_W-1:0]         r_p_qs;
    logic signed [MIX_W-1:0]         r_p_qc;
    logic signed [MIX_W-1:0]         r_p_is;
    logic signed [SAMPLE_WIDTH-1:0]  r_ri;
    logic signed [SAMPLE_WIDTH-1:0]  r_rq;
    logic signed [EPROD_W-1:0]       r_eprod;
    logic signed [PA_W-1:0]          r_pa;
    logic signed [PA_W-1:0]          r_pb;
    logic                            r_ge;
    logic signed [ERR_W-1:0]         r_err;
    logic signed [GTERM_W-1:0]       r_bterm;
    logic signed [GTERM_W-1:0]       r_aterm;

    logic [SINE_TABLE_BITS-1:0]      sin_idx;
    logic signed [SUM_W-1:0]         sum_i;
    logic signed [SUM_W-1:0]         sum_q;
    logic signed [SUM_W-1:0]         rnd_i;
    logic signed [SUM_W-1:0]         rnd_q;
    logic signed [SAMPLE_WIDTH-1:0]  n_ri;
    logic signed [SAMPLE_WIDTH-1:0]  n_rq;
    logic signed [PA_W-1:0]          n_pa;
    logic signed [PA_W-1:0]          n_pb;
    logic signed [PA_W-1:0]          abs_i;
    logic signed [PA_W-1:0]          abs_q;
    logic                            n_ge;
    logic signed [KOP_W-1:0]         mul_a;
    logic signed [KOP_W-1:0]         mul_b;
    logic signed [EW-1:0]            k_term;
    logic signed [EW-1:0]            raw_err;
    logic signed [ERR_W-1:0]         n_err;
    logic signed [GPROD_W-1:0]       n_bprod;
    logic signed [GPROD_W-1:0]       n_aprod;
    logic signed [FSUM_W-1:0]        n_freq;
    logic signed [FSUM_W-1:0]        freq_clamped;
    logic [PHASE_WIDTH-1:0]          n_phase;

    assign sin_idx = r_phase[PHASE_WIDTH-1 -: SINE_TABLE_BITS];

    // Rotation by -phase: round the Q14 sums and saturate
    always_comb begin
        sum_i = SUM_W'(r_p_ic) + SUM_W'(r_p_qs);
        sum_q = SUM_W'(r_p_qc) - SUM_W'(r_p_is);
        rnd_i = (sum_i + RND14) >>> 14;
        rnd_q = (sum_q + RND14) >>> 14;
        if (rnd_i > SMAX) begin
            n_ri = SAMPLE_WIDTH'(SMAX);
        end else if (rnd_i < SMIN) begin
            n_ri = SAMPLE_WIDTH'(SMIN);
        end else begin
            n_ri = SAMPLE_WIDTH'(rnd_i);
        end
        if (rnd_q > SMAX) begin
            n_rq = SAMPLE_WIDTH'(SMAX);
        end else if (rnd_q < SMIN) begin
            n_rq = SAMPLE_WIDTH'(SMIN);
        end else begin
            n_rq = SAMPLE_WIDTH'(rnd_q);
        end
    end

    // Sign decisions and the one shared detector multiplier
    always_comb begin
        n_pa  = (r_ri > 0) ? PA_W'(r_rq) : -PA_W'(r_rq);
        n_pb  = (r_rq > 0) ? PA_W'(r_ri) : -PA_W'(r_ri);
        abs_i = (r_ri < 0) ? -PA_W'(r_ri) : PA_W'(r_ri);
        abs_q = (r_rq < 0) ? -PA_W'(r_rq) : PA_W'(r_rq);
        n_ge  = (abs_i >= abs_q);
        if (r_mode == MODE_BPSK) begin
            mul_a = KOP_W'(r_ri);
            mul_b = KOP_W'(r_rq);
        end else begin
            mul_a = n_ge ? KOP_W'(n_pb) : KOP_W'(n_pa);
            mul_b = KOP_W'(K8PSK);
        end
    end

    // Phase error, clipped to +-1.0
    always_comb begin
        k_term = (EW'(r_eprod) + RND16) >>> 16;
        case (r_mode)
            MODE_BPSK: raw_err = (EW'(r_eprod) + RND_F) >>> FRAC_BITS;
            MODE_QPSK: raw_err = EW'(r_pa) - EW'(r_pb);
            MODE_8PSK: raw_err = r_ge ? (EW'(r_pa) - k_term) : (k_term - EW'(r_pb));
            default:   raw_err = '0;
        endcase
        if (raw_err > ERR_ONE) begin
            n_err = ERR_W'(ERR_ONE);
        end else if (raw_err < -ERR_ONE) begin
            n_err = ERR_W'(-ERR_ONE);
        end else begin
            n_err = ERR_W'(raw_err);
        end
    end

    // Loop filter gains, rounded into phase units
    assign n_bprod = GPROD_W'(signed'({1'b0, r_beta})) * GPROD_W'(r_err) + GRND;
    assign n_aprod = GPROD_W'(signed'({1'b0, r_alpha})) * GPROD_W'(r_err) + GRND;

    // NCO: phase steps by the unclamped frequency, frequency is then clamped
    always_comb begin
        n_freq  = FSUM_W'(r_nco_freq) + FSUM_W'(r_bterm);
        n_phase = r_phase + PHASE_WIDTH'(n_freq) + PHASE_WIDTH'(r_aterm);
        if (n_freq > FREQ_HI) begin
            freq_clamped = FREQ_HI;
        end else if (n_freq < FREQ_LO) begin
            freq_clamped = FREQ_LO;
        end else begin
            freq_clamped = n_freq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_QPSK;
            r_alpha    <= '0;
            r_beta     <= '0;
            r_phase    <= '0;
            r_nco_freq <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MODE:  r_mode  <= i_cfg_data[1:0];
                    REG_ALPHA: r_alpha <= i_cfg_data;
                    REG_BETA:  r_beta  <= i_cfg_data;
                    default:   ;
                endcase
            end
            if (i_cmd.update) begin
                r_phase    <= n_phase;
                r_nco_freq <= PHASE_WIDTH'(freq_clamped);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_xi  <= i_in_i;
            r_xq  <= i_in_q;
            r_sin <= sine_q14(sin_idx);
            r_cos <= sine_q14(sin_idx + SINE_TABLE_BITS'(SINE_QTR));
        end
        if (i_cmd.mix) begin
            r_p_ic <= MIX_W'(r_xi) * MIX_W'(r_cos);
            r_p_qs <= MIX_W'(r_xq) * MIX_W'(r_sin);
            r_p_qc <= MIX_W'(r_xq) * MIX_W'(r_cos);
            r_p_is <= MIX_W'(r_xi) * MIX_W'(r_sin);
        end
        if (i_cmd.round) begin
            r_ri <= n_ri;
            r_rq <= n_rq;
        end
        if (i_cmd.err_mul) begin
            r_eprod <= EPROD_W'(mul_a) * EPROD_W'(mul_b);
            r_pa    <= n_pa;
            r_pb    <= n_pb;
            r_ge    <= n_ge;
        end
        if (i_cmd.err_form) begin
            r_err <= n_err;
        end
        if (i_cmd.gain) begin
            r_bterm <= GTERM_W'(n_bprod >>> FRAC_BITS);
            r_aterm <= GTERM_W'(n_aprod >>> FRAC_BITS);
        end
    end

    assign o_out_i = r_ri;
    assign o_out_q = r_rq;

endmodule

// ===== sv/psk_costas_carrier_loop.sv =====
// PSK Costas carrier loop top: pcl_ctrl sequencer and pcl_dpath datapath; uses pcl_pkg.
// Output path: a sample accepted in idle is mixed, then rounded into the output register
//   as its derotated beat; rounding waits while an earlier beat is still stalled.
// Sample rate: a new sample is accepted only back in idle, once the phase feedback path
//   (mixer, detector multiply, gain multiply, NCO update) has closed for the last one.
// Reset: synchronous, active low; clears NCO phase, frequency and both gains, sets QPSK.
module psk_costas_carrier_loop (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // input sample channel
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  logic signed [pcl_pkg::SAMPLE_WIDTH-1:0]   i_in_i,
    input  logic signed [pcl_pkg::SAMPLE_WIDTH-1:0]   i_in_q,
    // derotated sample channel
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic signed [pcl_pkg::SAMPLE_WIDTH-1:0]   o_out_i,
    output logic signed [pcl_pkg::SAMPLE_WIDTH-1:0]   o_out_q,
    // configuration write channel
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [pcl_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [pcl_pkg::GAIN_W-1:0]                i_cfg_data
);
    import pcl_pkg::*;

    t_dp_cmd cmd;

    // Registers take a write in any cycle; software writes only while idle.
    assign o_cfg_ready = 1'b1;

    // Sequencer: accept a beat in idle, walk it through the loop, then
    // return to idle once the NCO has advanced.
    pcl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Datapath: the output register holds the derotated beat while the
    // loop filter and NCO finish in the background.
    pcl_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_i      (i_in_i),
        .i_in_q      (i_in_q),
        .o_out_i     (o_out_i),
        .o_out_q     (o_out_q)
    );

endmodule

// ===== dv/tb_psk_costas_carrier_loop.sv =====
// Self-checking testbench for the PSK Costas carrier loop: derotated I/Q beats
// are compared with a cycle-free predictor of the NCO, detector and loop filter.
// Depends on pcl_pkg and psk_costas_carrier_loop.
module tb_psk_costas_carrier_loop;
    import pcl_pkg::*;

    // Local codes not in the package: the spare register slot and the
    // unused detector setting (error forced to zero, loop coasts).
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
    localparam logic [1:0]           MODE_UNUSED = 2'd3;

    localparam int  SETTLE_CYCLES = 12;
    localparam int  HOLD_CYCLES   = 300;
    localparam int  LIMIT_CYCLES  = 1000000;
    localparam int  MAX_GAP       = 24;

    // One radian per sample in phase units, rounded down
    localparam longint ONE_RAD =
        longint'(((64'd1 << PHASE_WIDTH) * 64'd1000000000) / 64'd6283185307);
    localparam longint ERR_ONE = longint'(1) <<< FRAC_BITS;
    localparam longint S_MAX   = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint S_MIN   = -(longint'(1) <<< (SAMPLE_WIDTH - 1));

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] re;
        logic signed [SAMPLE_WIDTH-1:0] im;
    } t_iq_beat;

    // DUT ports
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    logic signed [SAMPLE_WIDTH-1:0] i_in_i      = '0;
    logic signed [SAMPLE_WIDTH-1:0] i_in_q      = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] o_out_i;
    logic signed [SAMPLE_WIDTH-1:0] o_out_q;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [CFG_IDX_W-1:0]           i_cfg_index = '0;
    logic [GAIN_W-1:0]              i_cfg_data  = '0;

    // Predictor copy of the loop registers and NCO state
    logic [1:0]             mode_sel    = MODE_QPSK;
    logic [GAIN_W-1:0]      alpha_gain  = '0;
    logic [GAIN_W-1:0]      beta_gain   = '0;
    logic [PHASE_WIDTH-1:0] nco_phase   = '0;
    longint                 nco_freq    = 0;

    // Derotated beats still owed by the block, oldest first
    t_iq_beat derot_q[$];

    // Idle rates in percent per cycle, and the long output hold-off request
    int  send_gap_pct   = 0;
    int  recv_stall_pct = 0;
    bit  hold_req       = 1'b0;

    int  fail_count    = 0;
    int  beats_checked = 0;
    int  samples_sent  = 0;
    int  settings_used = 0;

    psk_costas_carrier_loop dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_i      (i_in_i),
        .i_in_q      (i_in_q),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_i     (o_out_i),
        .o_out_q     (o_out_q),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor arithmetic
    // ------------------------------------------------------------------

    // Round half up: floor(v / 2^s + 1/2), arithmetic shift keeps the floor
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Decision sign: zero counts as negative
    function automatic longint decide(input longint v);
        return (v > 0) ? 64'sd1 : -64'sd1;
    endfunction

    // Q1.14 sine of a table index: fold into the first quadrant, evaluate
    // the odd fifth-order polynomial in Q16, drop to Q14, restore the sign.
    function automatic longint nco_sine(input logic [SINE_TABLE_BITS-1:0] idx);
        logic [1:0]        quad;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   poly;
        longint unsigned   mag;
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        x    = longint'(idx[SINE_QB-1:0]) << (16 - SINE_QB);
        if (quad[0]) begin
            x = 64'd65536 - x;
        end
        x2   = (x * x) >> 16;
        poly = 64'd42048 - ((x2 * 64'd4640) >> 16);
        poly = 64'd102944 - ((x2 * poly) >> 16);
        mag  = (((x * poly) >> 16) + 64'd2) >> 2;
        if (mag > 64'd16384) begin
            mag = 64'd16384;
        end
        return quad[1] ? -longint'(mag) : longint'(mag);
    endfunction

    // Derotate one accepted sample, queue the beat it owes, then close the
    // loop: detector, clip, integral and proportional paths, NCO advance.
    task automatic derotate_predict(input logic signed [SAMPLE_WIDTH-1:0] si,
                                    input logic signed [SAMPLE_WIDTH-1:0] sq);
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [SINE_TABLE_BITS-1:0] cidx;
        longint   sn;
        longint   cs;
        longint   xi;
        longint   xq;
        longint   ri;
        longint   rq;
        longint   pa;
        longint   pb;
        longint   err;
        longint   freq;
        longint   step;
        t_iq_beat beat;
        idx  = nco_phase[PHASE_WIDTH-1 -: SINE_TABLE_BITS];
        cidx = idx + SINE_TABLE_BITS'(SINE_QTR);
        sn   = nco_sine(idx);
        cs   = nco_sine(cidx);
        xi   = longint'(si);
        xq   = longint'(sq);
        ri   = clip(round_shift(xi * cs + xq * sn, 14), S_MIN, S_MAX);
        rq   = clip(round_shift(xq * cs - xi * sn, 14), S_MIN, S_MAX);
        beat.re = SAMPLE_WIDTH'(ri);
        beat.im = SAMPLE_WIDTH'(rq);
        derot_q.push_back(beat);

        case (mode_sel)
            MODE_BPSK: begin
                err = round_shift(ri * rq, FRAC_BITS);
            end
            MODE_QPSK: begin
                err = decide(ri) * rq - decide(rq) * ri;
            end
            MODE_8PSK: begin
                pa = decide(ri) * rq;
                pb = decide(rq) * ri;
                if (((ri < 0) ? -ri : ri) >= ((rq < 0) ? -rq : rq)) begin
                    err = pa - round_shift(pb * K8PSK, 16);
                end else begin
                    err = round_shift(pa * K8PSK, 16) - pb;
                end
            end
            default: begin
                err = 0;
            end
        endcase
        err = clip(err, -ERR_ONE, ERR_ONE);

        // Phase steps with the unclamped frequency; clamp only what is kept
        freq      = nco_freq + round_shift(longint'(beta_gain) * err, FRAC_BITS);
        step      = freq + round_shift(longint'(alpha_gain) * err, FRAC_BITS);
        nco_phase = nco_phase + PHASE_WIDTH'(step);
        nco_freq  = clip(freq, -ONE_RAD, ONE_RAD);
    endtask

    // ------------------------------------------------------------------
    // Checking and the output-side stall
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("ERROR [%0t] %s", $realtime, msg);
    endtask

    task automatic check_beat();
        t_iq_beat want;
        if (derot_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat i=%0d q=%0d", o_out_i, o_out_q));
        end else begin
            want = derot_q.pop_front();
            if (o_out_i !== want.re) begin
                report_mismatch($sformatf("beat %0d out_i got %0d want %0d",
                                          beats_checked, o_out_i, want.re));
            end
            if (o_out_q !== want.im) begin
                report_mismatch($sformatf("beat %0d out_q got %0d want %0d",
                                          beats_checked, o_out_q, want.im));
            end
        end
        beats_checked++;
    endtask

    // Sample the beat with pre-edge values, then pick the next stall. A hold
    // request locks the stall high for a fixed count of cycles, counted here.
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_beat();
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one sample: idle a random number of cycles first, then hold the
    // beat until the block takes it. Valid stays high on return so that a
    // back-to-back send need not raise it again.
    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] si,
                               input logic signed [SAMPLE_WIDTH-1:0] sq);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_gap_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_i     <= si;
        i_in_q     <= sq;
        do @(posedge i_clk); while (o_in_stall);
        derotate_predict(si, sq);
        samples_sent++;
    endtask

    // Drop valid, wait for every owed beat, then let the loop update finish
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (derot_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write; only called with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_MODE:  mode_sel   = data[1:0];
            REG_ALPHA: alpha_gain = data;
            REG_BETA:  beta_gain  = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Set all three loop registers; junk in the upper mode bits must be dropped
    task automatic set_loop(input logic [1:0] mode, input logic [GAIN_W-1:0] alpha,
                            input logic [GAIN_W-1:0] beta);
        write_reg(REG_MODE, {(GAIN_W - 2)'($urandom), mode});
        write_reg(REG_ALPHA, alpha);
        write_reg(REG_BETA, beta);
        settings_used++;
    endtask

    // Gains from zero through lock-friendly values up to full scale
    function automatic logic [GAIN_W-1:0] pick_gain();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return '0;
        end else if (pick <= 3) begin
            return GAIN_W'($urandom_range(0, 1 << 20));
        end else if (pick <= 6) begin
            return GAIN_W'($urandom_range(1 << 20, 1 << 26));
        end else if (pick <= 8) begin
            return GAIN_W'($urandom);
        end
        return {GAIN_W{1'b1}};
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_corner();
        case ($urandom_range(0, 4))
            0:       return SAMPLE_WIDTH'(S_MIN);
            1:       return SAMPLE_WIDTH'(-1);
            2:       return '0;
            3:       return SAMPLE_WIDTH'(1);
            default: return SAMPLE_WIDTH'(S_MAX);
        endcase
    endfunction

    // Mostly constellation points of the current order with amplitude and
    // noise; the rest is full-range noise and field corners.
    task automatic gen_sample(output logic signed [SAMPLE_WIDTH-1:0] si,
                              output logic signed [SAMPLE_WIDTH-1:0] sq);
        int     pick;
        longint amp;
        longint diag;
        longint ni;
        longint nq;
        longint vi;
        longint vq;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            si = SAMPLE_WIDTH'($urandom);
            sq = SAMPLE_WIDTH'($urandom);
        end else if (pick < 45) begin
            si = pick_corner();
            sq = pick_corner();
        end else begin
            amp  = longint'($urandom_range(4096, 23170));
            diag = (amp * 46341) >>> 16;
            ni   = longint'($urandom_range(0, 1024)) - 512;
            nq   = longint'($urandom_range(0, 1024)) - 512;
            case (mode_sel)
                MODE_BPSK: begin
                    vi = $urandom_range(0, 1) ? amp : -amp;
                    vq = 0;
                end
                MODE_8PSK: begin
                    case ($urandom_range(0, 7))
                        0:       begin vi = amp;   vq = 0;     end
                        1:       begin vi = diag;  vq = diag;  end
                        2:       begin vi = 0;     vq = amp;   end
                        3:       begin vi = -diag; vq = diag;  end
                        4:       begin vi = -amp;  vq = 0;     end
                        5:       begin vi = -diag; vq = -diag; end
                        6:       begin vi = 0;     vq = -amp;  end
                        default: begin vi = diag;  vq = -diag; end
                    endcase
                end
                default: begin
                    vi = $urandom_range(0, 1) ? amp : -amp;
                    vq = $urandom_range(0, 1) ? amp : -amp;
                end
            endcase
            si = SAMPLE_WIDTH'(vi + ni);
            sq = SAMPLE_WIDTH'(vq + nq);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field corners under every detector setting. Gains are chosen so that
    // the BPSK pass swings phase with the largest proportional gain, the QPSK
    // pass drives frequency into its clamp, and the unused setting coasts on
    // whatever frequency was left. A write to the spare slot must change nothing.
    task automatic test_directed_modes();
        logic [1:0] mode;
        drain_and_settle();
        write_reg(REG_SPARE, {GAIN_W{1'b1}});
        for (int k = 0; k < 4; k++) begin
            mode = 2'(k);
            drain_and_settle();
            case (mode)
                MODE_BPSK: set_loop(mode, {GAIN_W{1'b1}}, '0);
                MODE_QPSK: set_loop(mode, '0, {GAIN_W{1'b1}});
                MODE_8PSK: set_loop(mode, GAIN_W'(1 << 24), GAIN_W'(1 << 18));
                default:   set_loop(mode, {GAIN_W{1'b1}}, {GAIN_W{1'b1}});
            endcase
            // zero samples hit the "zero decides negative" rule
            send_sample('0, '0);
            send_sample(SAMPLE_WIDTH'(S_MAX), SAMPLE_WIDTH'(S_MAX));
            send_sample(SAMPLE_WIDTH'(S_MIN), SAMPLE_WIDTH'(S_MIN));
            send_sample(SAMPLE_WIDTH'(S_MIN), SAMPLE_WIDTH'(S_MAX));
            send_sample(SAMPLE_WIDTH'(12000), SAMPLE_WIDTH'(-3000));
            if (mode == MODE_8PSK) begin
                // one sample near each axis so both 8-PSK branches are taken
                send_sample(SAMPLE_WIDTH'(20000), SAMPLE_WIDTH'(1500));
                send_sample(SAMPLE_WIDTH'(1500), SAMPLE_WIDTH'(20000));
            end
        end
    endtask

    // A run of random loop settings, each followed by a burst of samples
    task automatic test_random_loop(input int n_settings, input int n_items);
        logic signed [SAMPLE_WIDTH-1:0] si;
        logic signed [SAMPLE_WIDTH-1:0] sq;
        int         pick;
        logic [1:0] mode;
        for (int s = 0; s < n_settings; s++) begin
            drain_and_settle();
            pick = $urandom_range(0, 9);
            mode = (pick < 3) ? MODE_BPSK : (pick < 6) ? MODE_QPSK :
                   (pick < 9) ? MODE_8PSK : MODE_UNUSED;
            set_loop(mode, pick_gain(), pick_gain());
            for (int k = 0; k < n_items; k++) begin
                gen_sample(si, sq);
                send_sample(si, sq);
            end
        end
    endtask

    // Hold the output off long enough for the block to back up and stall its
    // input while samples keep coming; pause until all beats are back, then send a second burst.
    task automatic test_backpressure();
        logic signed [SAMPLE_WIDTH-1:0] si;
        logic signed [SAMPLE_WIDTH-1:0] sq;
        drain_and_settle();
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++) begin
            gen_sample(si, sq);
            send_sample(si, sq);
        end
        drain_and_settle();
        for (int k = 0; k < 40; k++) begin
            gen_sample(si, sq);
            send_sample(si, sq);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender sparse, receiver stalls often
        send_gap_pct   = 32;
        recv_stall_pct = 64;
        test_directed_modes();
        test_random_loop(4, 112);

        // the other way round
        send_gap_pct   = 64;
        recv_stall_pct = 32;
        test_random_loop(4, 112);

        // full rate both sides
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random_loop(4, 112);
        test_backpressure();

        drain_and_settle();
        $display("Run covered %0d samples over %0d loop settings (all detector modes).",
                 samples_sent, settings_used);
        $display("Beats checked: %0d, errors: %0d, output hold-off %0d cycles.",
                 beats_checked, fail_count, HOLD_CYCLES);
        if (fail_count == 0 && derot_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #(LIMIT_CYCLES * 12);
        $display("Timeout with %0d beats still owed.", derot_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
